[hdl/wfps_pkg.sv]
// Shared constants, types, window and twiddle tables for the windowed FFT power spectrum core.
`default_nettype none
package wfps_pkg;

  localparam int POINTS      = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int AW          = $clog2(POINTS);       // frame store address
  localparam int BF_W        = AW - 1;               // butterfly counter / twiddle index
  localparam int TW_N        = POINTS / 2;
  localparam int ST_W        = $clog2(AW);           // stage counter
  localparam int DW          = SAMPLE_BITS + AW + 2; // one component in the store
  localparam int WIN_W       = 17;
  localparam int TW_W        = 32;
  localparam int PR_W        = DW + TW_W;
  localparam int P_W         = 2 * DW;               // power word
  localparam int SH_W        = $clog2(P_W);
  localparam int M_W         = 31;                   // log mantissa, Q30
  localparam int FRAC_W      = 16;
  localparam int IT_W        = $clog2(FRAC_W);
  localparam int L_W         = 24;
  localparam int K_W         = 19;
  localparam int SCL_W       = L_W + K_W;
  localparam int BIN_W       = 6;
  localparam int DB_W        = 16;
  localparam int WIN_DEN     = POINTS - 1;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic signed [63:0] HAM_A_Q30 = 64'sd579820585;
  localparam logic signed [63:0] HAM_B_Q30 = 64'sd493921239;
  localparam logic signed [63:0] DB_FLOOR  = -64'sd25600;
  localparam logic signed [63:0] DB_CEIL   = 64'sd10240;
  localparam logic signed [K_W-1:0] DB_K   = K_W'(197283);
  localparam logic signed [L_W-1:0] LOG_OFS_Q16 =
    L_W'((2 * (SAMPLE_BITS - 1)) * (2 ** FRAC_W));

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_BF_LOAD,
    OP_BF_ROT,
    OP_SQ,
    OP_SUM,
    OP_NORM,
    OP_LOG,
    OP_SCALE,
    OP_PUSH,
    OP_PUSH_OVR
  } dp_op_e;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_SAMPLE,
    WR_TOP,
    WR_BOT
  } wr_sel_e;

  typedef struct packed {
    dp_op_e          op;
    wr_sel_e         wr_sel;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr_a;
    logic [AW-1:0]   rd_addr_b;
    logic [AW-1:0]   win_idx;
    logic [BF_W-1:0] tw_idx;
    logic [AW-1:0]   bin;
    logic            last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic norm_done;
    logic p_zero;
  } dp_sts_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } cs_t;

  typedef logic signed [WIN_W-1:0] win_rom_t [POINTS];
  typedef logic signed [TW_W-1:0]  tw_rom_t  [TW_N];

  // Shift right by n, rounding half away from zero.
  function automatic logic signed [63:0] sra_round(logic signed [63:0] v, int n);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // cos and sin in Q30 of a phase in 2^-32 turn.
  function automatic cs_t sincos_q30(logic [31:0] phase);
    logic [63:0] r, x, x2, tc, ts;
    logic signed [63:0] c, s, t;
    logic fold;
    cs_t res;
    r    = {34'd0, phase[29:0]};
    fold = r > (Q30_ONE >> 1);
    if (fold) r = Q30_ONE - r;
    x  = (r * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    tc = Q30_ONE;
    ts = Q30_ONE;
    tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd90;
    ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd110;
    tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd56;
    ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd72;
    tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd30;
    ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd42;
    tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd12;
    ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd20;
    tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd2;
    ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd6;
    c = $signed(tc);
    s = $signed((x * ts) >> 30);
    if (fold) begin
      t = c;
      c = s;
      s = t;
    end
    case (phase[31:30])
      2'd0:    begin res.c = c;  res.s = s;  end
      2'd1:    begin res.c = -s; res.s = c;  end
      2'd2:    begin res.c = -c; res.s = -s; end
      default: begin res.c = s;  res.s = -c; end
    endcase
    return res;
  endfunction

  function automatic logic signed [WIN_W-1:0] window_q15(int i);
    logic [63:0] ph;
    cs_t cs;
    logic signed [63:0] w30;
    ph  = ((64'(i) << 32) + 64'(WIN_DEN / 2)) / WIN_DEN;
    cs  = sincos_q30(ph[31:0]);
    w30 = HAM_A_Q30 - sra_round(HAM_B_Q30 * cs.c, 30);
    return WIN_W'(sra_round(w30, 15));
  endfunction

  function automatic win_rom_t make_win();
    win_rom_t r;
    for (int i = 0; i < POINTS; i++) r[i] = window_q15(i);
    return r;
  endfunction

  function automatic tw_rom_t make_tw(logic want_sin);
    tw_rom_t r;
    logic [31:0] ph;
    cs_t cs;
    for (int t = 0; t < TW_N; t++) begin
      ph   = 32'd0 - (32'(t) << (32 - AW));
      cs   = sincos_q30(ph);
      r[t] = want_sin ? TW_W'(cs.s) : TW_W'(cs.c);
    end
    return r;
  endfunction

  localparam win_rom_t WIN_ROM = make_win();
  localparam tw_rom_t  TW_RE   = make_tw(1'b0);
  localparam tw_rom_t  TW_IM   = make_tw(1'b1);

  function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] a);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) r[i] = a[AW-1-i];
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/wfps_if.sv]
// Valid/ready channel interfaces for sample words and spectrum words.
`default_nettype none
interface wfps_in_if import wfps_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_re;
  logic signed [SAMPLE_BITS-1:0] sample_im;
  logic                          chunk_end;

  modport source (output valid, sample_re, sample_im, chunk_end, input ready);
  modport sink   (input valid, sample_re, sample_im, chunk_end, output ready);
endinterface

interface wfps_out_if import wfps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BIN_W-1:0]        bin_index;
  logic signed [DB_W-1:0]  power_db;
  logic                    overrun;
  logic                    run_last;

  modport source (output valid, bin_index, power_db, overrun, run_last, input ready);
  modport sink   (input valid, bin_index, power_db, overrun, run_last, output ready);
endinterface
`default_nettype wire

[hdl/wfps_ram.sv]
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module wfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

[hdl/wfps_ctrl.sv]
// Sequencer: load, zero pad, butterfly passes and per-bin log steps.
`default_nettype none
module wfps_ctrl import wfps_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    chunk_end_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_OVR,
    S_PAD,
    S_BF_RD,
    S_BF_MUL,
    S_BF_ROT,
    S_BF_WT,
    S_BF_WB,
    S_EM_RD,
    S_EM_SQ,
    S_EM_SUM,
    S_EM_NORM,
    S_EM_LOG,
    S_EM_SCALE,
    S_EM_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [AW:0]       fill_q, fill_d;
  logic              too_long_q, too_long_d;
  logic [AW:0]       cnt_q, cnt_d;
  logic [BF_W-1:0]   bf_q, bf_d;
  logic [ST_W-1:0]   stage_q, stage_d;
  logic [IT_W-1:0]   iter_q, iter_d;

  logic [BF_W-1:0]   bf_mask, bf_lo, bf_hi;
  logic [AW-1:0]     top_addr, bot_addr;

  // Butterfly addressing for span 2^stage.
  always_comb begin
    bf_mask  = BF_W'((1 << stage_q) - 1);
    bf_lo    = bf_q & bf_mask;
    bf_hi    = bf_q >> stage_q;
    top_addr = AW'({1'b0, bf_hi} << (stage_q + 1)) | AW'(bf_lo);
    bot_addr = top_addr | (AW'(1) << stage_q);
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    too_long_d = too_long_q;
    cnt_d      = cnt_q;
    bf_d       = bf_q;
    stage_d    = stage_q;
    iter_d     = iter_q;
    in_ready_o = 1'b0;

    cmd_o           = '0;
    cmd_o.op        = OP_IDLE;
    cmd_o.wr_sel    = WR_ZERO;
    cmd_o.rd_addr_a = top_addr;
    cmd_o.rd_addr_b = bot_addr;
    cmd_o.tw_idx    = BF_W'(bf_lo << (AW - 1 - stage_q));
    cmd_o.win_idx   = fill_q[AW-1:0];
    cmd_o.bin       = cnt_q[AW-1:0];
    cmd_o.last      = (cnt_q[AW-1:0] == AW'(POINTS - 1));

    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!fill_q[AW]) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_sel  = WR_SAMPLE;
            cmd_o.wr_addr = bit_rev(fill_q[AW-1:0]);
            fill_d        = fill_q + 1'b1;
          end else begin
            too_long_d = 1'b1;
          end
          if (chunk_end_i) begin
            fill_d     = '0;
            too_long_d = 1'b0;
            if (fill_q[AW]) begin
              state_d = S_OVR;
            end else begin
              cnt_d   = fill_q + 1'b1;
              state_d = S_PAD;
            end
          end
        end
      end
      S_OVR: begin
        if (sts_i.slot_free) begin
          cmd_o.op = OP_PUSH_OVR;
          state_d  = S_LOAD;
        end
      end
      S_PAD: begin
        if (cnt_q[AW]) begin
          bf_d    = '0;
          stage_d = '0;
          state_d = S_BF_RD;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_ZERO;
          cmd_o.wr_addr = bit_rev(cnt_q[AW-1:0]);
          cnt_d         = cnt_q + 1'b1;
        end
      end
      S_BF_RD:  state_d = S_BF_MUL;
      S_BF_MUL: begin
        cmd_o.op = OP_BF_LOAD;
        state_d  = S_BF_ROT;
      end
      S_BF_ROT: begin
        cmd_o.op = OP_BF_ROT;
        state_d  = S_BF_WT;
      end
      S_BF_WT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_TOP;
        cmd_o.wr_addr = top_addr;
        state_d       = S_BF_WB;
      end
      S_BF_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_BOT;
        cmd_o.wr_addr = bot_addr;
        state_d       = S_BF_RD;
        if (bf_q == '1) begin
          bf_d = '0;
          if (stage_q == ST_W'(AW - 1)) begin
            cnt_d   = '0;
            state_d = S_EM_RD;
          end else begin
            stage_d = stage_q + 1'b1;
          end
        end else begin
          bf_d = bf_q + 1'b1;
        end
      end
      S_EM_RD: begin
        cmd_o.rd_addr_a = cnt_q[AW-1:0];
        state_d         = S_EM_SQ;
      end
      S_EM_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_EM_SUM;
      end
      S_EM_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_EM_NORM;
      end
      S_EM_NORM: begin
        if (sts_i.p_zero) begin
          state_d = S_EM_OUT;
        end else begin
          cmd_o.op = OP_NORM;
          if (sts_i.norm_done) begin
            iter_d  = '0;
            state_d = S_EM_LOG;
          end
        end
      end
      S_EM_LOG: begin
        cmd_o.op = OP_LOG;
        iter_d   = iter_q + 1'b1;
        if (iter_q == IT_W'(FRAC_W - 1)) state_d = S_EM_SCALE;
      end
      S_EM_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.op = OP_PUSH;
          if (cmd_o.last) begin
            state_d = S_LOAD;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_EM_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      fill_q     <= '0;
      too_long_q <= 1'b0;
      cnt_q      <= '0;
      bf_q       <= '0;
      stage_q    <= '0;
      iter_q     <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      too_long_q <= too_long_d;
      cnt_q      <= cnt_d;
      bf_q       <= bf_d;
      stage_q    <= stage_d;
      iter_q     <= iter_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (AW + 1)'(POINTS))
    else $error("fill count past frame size");

  a_too_long_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_long_q |-> (fill_q == (AW + 1)'(POINTS)))
    else $error("overrun flagged on a frame that is not full");

endmodule
`default_nettype wire

[hdl/wfps_dp.sv]
// Datapath: windowing, frame store, butterfly unit, power and log2 units, output register.
`default_nettype none
module wfps_dp import wfps_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dp_cmd_t                       cmd_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_im_i,
  output dp_sts_t                            sts_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [BIN_W-1:0]                   bin_index_o,
  output logic signed [DB_W-1:0]             power_db_o,
  output logic                               overrun_o,
  output logic                               run_last_o
);

  logic [2*DW-1:0] rd_a, rd_b, wdata;
  logic signed [DW-1:0] a_re, a_im, b_re, b_im;

  logic signed [WIN_W-1:0]             win_c;
  logic signed [SAMPLE_BITS+WIN_W-1:0] wp_re, wp_im;
  logic signed [63:0]                  ws_re, ws_im;

  logic signed [TW_W-1:0] tw_re, tw_im;
  logic signed [DW-1:0]   u_re_q, u_im_q, v_re_q, v_im_q;
  logic signed [PR_W-1:0] pr_q [4];
  logic signed [63:0]     rot_re, rot_im;

  logic [P_W-1:0]   sq_re_q, sq_im_q, p_q, p_sum;
  logic             pzero_q;
  logic [SH_W-1:0]  sh_q, e_val;
  logic [M_W-1:0]   m_q;
  logic [2*M_W-1:0] m_sq;
  logic [31:0]      m_t;
  logic [FRAC_W-1:0] frac_q;
  logic signed [L_W-1:0]   l_val;
  logic signed [SCL_W-1:0] scl_q;
  logic signed [63:0]      db_rnd;
  logic signed [DB_W-1:0]  db_val;

  assign a_re = rd_a[2*DW-1:DW];
  assign a_im = rd_a[DW-1:0];
  assign b_re = rd_b[2*DW-1:DW];
  assign b_im = rd_b[DW-1:0];

  // Window each sample on its way into the store.
  assign win_c = WIN_ROM[cmd_i.win_idx];
  assign wp_re = sample_re_i * win_c;
  assign wp_im = sample_im_i * win_c;
  assign ws_re = sra_round(64'(wp_re), 15);
  assign ws_im = sra_round(64'(wp_im), 15);

  always_comb begin
    case (cmd_i.wr_sel)
      WR_SAMPLE: wdata = {ws_re[DW-1:0], ws_im[DW-1:0]};
      WR_TOP:    wdata = {DW'(u_re_q + v_re_q), DW'(u_im_q + v_im_q)};
      WR_BOT:    wdata = {DW'(u_re_q - v_re_q), DW'(u_im_q - v_im_q)};
      default:   wdata = '0;
    endcase
  end

  wfps_ram #(
    .WIDTH (2 * DW),
    .DEPTH (POINTS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.wr_en),
    .waddr_i   (cmd_i.wr_addr),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.rd_addr_a),
    .raddr_b_i (cmd_i.rd_addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign tw_re  = TW_RE[cmd_i.tw_idx];
  assign tw_im  = TW_IM[cmd_i.tw_idx];
  assign rot_re = sra_round(64'(pr_q[0]) - 64'(pr_q[1]), 30);
  assign rot_im = sra_round(64'(pr_q[2]) + 64'(pr_q[3]), 30);

  assign p_sum = sq_re_q + sq_im_q;
  assign m_sq  = m_q * m_q;
  assign m_t   = m_sq[2*M_W-1:30];
  assign e_val = SH_W'(P_W - 1) - sh_q;
  assign l_val = $signed({(L_W - FRAC_W)'(e_val), frac_q}) - LOG_OFS_Q16;

  // Round Q32 product to Q8.8 and clamp to the dB range.
  always_comb begin
    db_rnd = sra_round(64'(scl_q), 24);
    if (pzero_q || db_rnd < DB_FLOOR) begin
      db_val = DB_W'(DB_FLOOR);
    end else if (db_rnd > DB_CEIL) begin
      db_val = DB_W'(DB_CEIL);
    end else begin
      db_val = DB_W'(db_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_BF_LOAD: begin
        u_re_q  <= a_re;
        u_im_q  <= a_im;
        pr_q[0] <= b_re * tw_re;
        pr_q[1] <= b_im * tw_im;
        pr_q[2] <= b_re * tw_im;
        pr_q[3] <= b_im * tw_re;
      end
      OP_BF_ROT: begin
        v_re_q <= rot_re[DW-1:0];
        v_im_q <= rot_im[DW-1:0];
      end
      OP_SQ: begin
        sq_re_q <= a_re * a_re;
        sq_im_q <= a_im * a_im;
      end
      OP_SUM: begin
        p_q     <= p_sum;
        pzero_q <= (p_sum == '0);
        sh_q    <= '0;
      end
      OP_NORM: begin
        // Coarse then fine shift until the leading one sits at the top.
        if (p_q[P_W-1]) begin
          m_q    <= p_q[P_W-1 -: M_W];
          frac_q <= '0;
        end else if (p_q[P_W-1 -: 8] == '0) begin
          p_q  <= p_q << 8;
          sh_q <= sh_q + SH_W'(8);
        end else begin
          p_q  <= p_q << 1;
          sh_q <= sh_q + 1'b1;
        end
      end
      OP_LOG: begin
        if (m_t[31]) begin
          m_q    <= m_t[31:1];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b1};
        end else begin
          m_q    <= m_t[30:0];
          frac_q <= {frac_q[FRAC_W-2:0], 1'b0};
        end
      end
      OP_SCALE: scl_q <= l_val * DB_K;
      OP_PUSH: begin
        bin_index_o <= BIN_W'(cmd_i.bin);
        power_db_o  <= db_val;
        overrun_o   <= 1'b0;
        run_last_o  <= cmd_i.last;
      end
      OP_PUSH_OVR: begin
        bin_index_o <= '0;
        power_db_o  <= '0;
        overrun_o   <= 1'b1;
        run_last_o  <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else if (cmd_i.op == OP_PUSH || cmd_i.op == OP_PUSH_OVR) begin
      res_valid_o <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_o <= 1'b0;
    end
  end

  assign sts_o.slot_free = !res_valid_o || res_ready_i;
  assign sts_o.norm_done = p_q[P_W-1];
  assign sts_o.p_zero    = pzero_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PUSH || cmd_i.op == OP_PUSH_OVR) |-> (!res_valid_o || res_ready_i))
    else $error("result pushed over an untaken word");

  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.op == OP_LOG) |-> m_q[M_W-1])
    else $error("log mantissa lost normalization");

endmodule
`default_nettype wire

[hdl/windowed_fft_power_spectrum_db_core.sv]
// Top level of the Hamming-windowed FFT power spectrum core (dB per bin).
// Each sample word is accepted while the frame loads; after the chunk-end word the core
// zero pads the rest of the frame (one entry per cycle), then runs 6 x 32 butterflies,
// each through read, multiply, rotate and two write steps on the shared butterfly unit
// and store ports, then emits one word per bin after the normalize and 16-step
// log2 loops. Reset clears the sequencer and output valid; the frame store is not cleared.
`default_nettype none
module windowed_fft_power_spectrum_db_core import wfps_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wfps_in_if.sink    smp_i,
  wfps_out_if.source res_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  // Sequencer: owns fill count, overrun flag and all loop counters.
  wfps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (smp_i.valid),
    .chunk_end_i (smp_i.chunk_end),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Accept sample words only while the frame is loading.
  assign smp_i.ready = in_ready;

  // Datapath: frame store, butterfly and log units, plus the output word register
  // that lets the next chunk start loading while the last word still waits.
  wfps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_re_i (smp_i.sample_re),
    .sample_im_i (smp_i.sample_im),
    .sts_o       (sts),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .bin_index_o (res_o.bin_index),
    .power_db_o  (res_o.power_db),
    .overrun_o   (res_o.overrun),
    .run_last_o  (res_o.run_last)
  );

endmodule
`default_nettype wire
